// ===== rtl/iotk_pkg.sv =====
// ============================================================================
// iotk_pkg: shared types and constants of the I/O top-K usage tracker
// Holds the rank entry type, the control state type, the result kind codes
// and the register index codes.
// ============================================================================
package iotk_pkg;

    localparam int TOP_COUNT_DEF = 5;

    localparam int UID_W   = 32;
    localparam int BYTES_W = 48;
    localparam int SYNC_W  = 32;
    localparam int TOTAL_W = 56;
    localparam int KEY_W   = BYTES_W + 1;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = TOTAL_W;

    localparam logic [CFG_INDEX_W-1:0] CFG_READ_MIN  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WRITE_MIN = 2'd1;

    localparam logic [1:0] KIND_TOTAL = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [UID_W-1:0]   uid;
        logic [BYTES_W-1:0] fg_read;
        logic [BYTES_W-1:0] bg_read;
        logic [BYTES_W-1:0] fg_write;
        logic [BYTES_W-1:0] bg_write;
        logic [SYNC_W-1:0]  fg_sync;
        logic [SYNC_W-1:0]  bg_sync;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_REPORT
    } state_t;

endpackage

// ===== rtl/io_top_k_usage_tracker_unit.sv =====
// ============================================================================
// io_top_k_usage_tracker_unit: per-user I/O totals and top-K rankings
// Sums I/O records over an interval and reports totals and two top-K lists.
// ============================================================================
// A record is taken at a clock edge with start high and busy low. Ordinary
// records are taken back to back, one per cycle; each walks the read and the
// write rank chains one cell per cycle while the totals update at once.
// A record with interval_end set makes busy rise. The chains drain, then the
// report follows as 1 + 2*TOP_COUNT beats in consecutive cycles, each marked
// by out_valid for one cycle: the totals beat, the read ranks and then the
// write ranks, with report_last on the final beat. Busy falls in the cycle
// of the final beat, when the lists and totals have been cleared. The
// receiver cannot stall the report. Registers are written through cfg_we,
// cfg_index and cfg_wdata; the user must write them only while the block is
// idle, which the block itself does not enforce. Reset clears totals, both
// lists and the registers.
// ============================================================================
module io_top_k_usage_tracker_unit #(
    parameter int TOP_COUNT = iotk_pkg::TOP_COUNT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [iotk_pkg::UID_W-1:0]        user_id,
    input  logic [iotk_pkg::BYTES_W-1:0]      fg_read_bytes,
    input  logic [iotk_pkg::BYTES_W-1:0]      bg_read_bytes,
    input  logic [iotk_pkg::BYTES_W-1:0]      fg_write_bytes,
    input  logic [iotk_pkg::BYTES_W-1:0]      bg_write_bytes,
    input  logic [iotk_pkg::SYNC_W-1:0]       fg_sync_count,
    input  logic [iotk_pkg::SYNC_W-1:0]       bg_sync_count,
    input  logic                              interval_end,
    input  logic                              cfg_we,
    input  logic [iotk_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [iotk_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output logic                              out_valid,
    output logic [1:0]                        record_kind,
    output logic [3:0]                        rank_index,
    output logic [iotk_pkg::UID_W-1:0]        out_user_id,
    output logic [iotk_pkg::TOTAL_W-1:0]      out_fg_read,
    output logic [iotk_pkg::TOTAL_W-1:0]      out_bg_read,
    output logic [iotk_pkg::TOTAL_W-1:0]      out_fg_write,
    output logic [iotk_pkg::TOTAL_W-1:0]      out_bg_write,
    output logic [iotk_pkg::TOTAL_W-1:0]      out_fg_sync,
    output logic [iotk_pkg::TOTAL_W-1:0]      out_bg_sync,
    output logic                              shown,
    output logic                              report_last
);
    import iotk_pkg::*;

    localparam int SLOT_W = $clog2(2 * TOP_COUNT + 1);
    localparam int RANK_W = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;

    function automatic logic [TOTAL_W-1:0] sat_add(
        input logic [TOTAL_W-1:0] a,
        input logic [TOTAL_W-1:0] b
    );
        logic [TOTAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
    endfunction

    state_t              state_reg;
    state_t              state_next;
    logic [SLOT_W-1:0]   cnt_reg;
    logic [SLOT_W-1:0]   cnt_next;
    logic                accept;
    logic                clear_lists;
    logic                ok_load;
    logic                beat_valid;

    entry_t              rd_rec;
    entry_t              wr_rec;
    entry_t              rd_entries [TOP_COUNT];
    entry_t              wr_entries [TOP_COUNT];

    logic [TOTAL_W-1:0]  tot_fg_read_reg;
    logic [TOTAL_W-1:0]  tot_bg_read_reg;
    logic [TOTAL_W-1:0]  tot_fg_write_reg;
    logic [TOTAL_W-1:0]  tot_bg_write_reg;
    logic [TOTAL_W-1:0]  tot_fg_sync_reg;
    logic [TOTAL_W-1:0]  tot_bg_sync_reg;
    logic [TOTAL_W-1:0]  rd_min_reg;
    logic [TOTAL_W-1:0]  wr_min_reg;
    logic                rd_ok_reg;
    logic                wr_ok_reg;

    logic                in_rd;
    logic [SLOT_W-1:0]   rank_full;
    logic [RANK_W-1:0]   rank_sel;
    entry_t              sel_entry;
    logic [1:0]          kind_next;
    logic [3:0]          rank_next;
    logic [UID_W-1:0]    uid_next;
    logic [TOTAL_W-1:0]  fr_next;
    logic [TOTAL_W-1:0]  br_next;
    logic [TOTAL_W-1:0]  fw_next;
    logic [TOTAL_W-1:0]  bw_next;
    logic [TOTAL_W-1:0]  fs_next;
    logic [TOTAL_W-1:0]  bs_next;
    logic                shown_next;
    logic                last_next;

    logic                out_valid_reg;
    logic [1:0]          record_kind_reg;
    logic [3:0]          rank_index_reg;
    logic [UID_W-1:0]    out_user_id_reg;
    logic [TOTAL_W-1:0]  out_fg_read_reg;
    logic [TOTAL_W-1:0]  out_bg_read_reg;
    logic [TOTAL_W-1:0]  out_fg_write_reg;
    logic [TOTAL_W-1:0]  out_bg_write_reg;
    logic [TOTAL_W-1:0]  out_fg_sync_reg;
    logic [TOTAL_W-1:0]  out_bg_sync_reg;
    logic                shown_reg;
    logic                report_last_reg;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        rd_rec = '0;
        wr_rec = '0;
        if (accept)
        begin
            rd_rec.uid      = user_id;
            rd_rec.fg_read  = fg_read_bytes;
            rd_rec.bg_read  = bg_read_bytes;
            rd_rec.fg_write = fg_write_bytes;
            rd_rec.bg_write = bg_write_bytes;
            rd_rec.fg_sync  = fg_sync_count;
            rd_rec.bg_sync  = bg_sync_count;
            wr_rec          = rd_rec;
            rd_rec.key      = {1'b0, fg_read_bytes} + {1'b0, bg_read_bytes};
            wr_rec.key      = {1'b0, fg_write_bytes} + {1'b0, bg_write_bytes};
        end
    end

    iotk_rank_chain #(
        .TOP_COUNT (TOP_COUNT)
    ) u_rd_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (clear_lists),
        .rec_in  (rd_rec),
        .entries (rd_entries)
    );

    iotk_rank_chain #(
        .TOP_COUNT (TOP_COUNT)
    ) u_wr_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (clear_lists),
        .rec_in  (wr_rec),
        .entries (wr_entries)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tot_fg_read_reg  <= '0;
            tot_bg_read_reg  <= '0;
            tot_fg_write_reg <= '0;
            tot_bg_write_reg <= '0;
            tot_fg_sync_reg  <= '0;
            tot_bg_sync_reg  <= '0;
        end
        else if (clear_lists)
        begin
            tot_fg_read_reg  <= '0;
            tot_bg_read_reg  <= '0;
            tot_fg_write_reg <= '0;
            tot_bg_write_reg <= '0;
            tot_fg_sync_reg  <= '0;
            tot_bg_sync_reg  <= '0;
        end
        else if (accept)
        begin
            tot_fg_read_reg  <= sat_add(tot_fg_read_reg, TOTAL_W'(fg_read_bytes));
            tot_bg_read_reg  <= sat_add(tot_bg_read_reg, TOTAL_W'(bg_read_bytes));
            tot_fg_write_reg <= sat_add(tot_fg_write_reg, TOTAL_W'(fg_write_bytes));
            tot_bg_write_reg <= sat_add(tot_bg_write_reg, TOTAL_W'(bg_write_bytes));
            tot_fg_sync_reg  <= sat_add(tot_fg_sync_reg, TOTAL_W'(fg_sync_count));
            tot_bg_sync_reg  <= sat_add(tot_bg_sync_reg, TOTAL_W'(bg_sync_count));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_min_reg <= '0;
            wr_min_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_READ_MIN:  rd_min_reg <= cfg_wdata;
                CFG_WRITE_MIN: wr_min_reg <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ok_reg <= 1'b0;
            wr_ok_reg <= 1'b0;
        end
        else if (ok_load)
        begin
            rd_ok_reg <= ({1'b0, tot_fg_read_reg} + {1'b0, tot_bg_read_reg})
                         >= {1'b0, rd_min_reg};
            wr_ok_reg <= ({1'b0, tot_fg_write_reg} + {1'b0, tot_bg_write_reg})
                         >= {1'b0, wr_min_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        clear_lists = 1'b0;
        ok_load     = 1'b0;
        beat_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && interval_end)
                begin
                    state_next = ST_DRAIN;
                    cnt_next   = '0;
                end
            end
            ST_DRAIN:
            begin
                if (cnt_reg == SLOT_W'(TOP_COUNT - 1))
                begin
                    state_next = ST_REPORT;
                    cnt_next   = '0;
                    ok_load    = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_REPORT:
            begin
                beat_valid = 1'b1;
                if (cnt_reg == SLOT_W'(2 * TOP_COUNT))
                begin
                    state_next  = ST_IDLE;
                    cnt_next    = '0;
                    clear_lists = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    always_comb
    begin
        in_rd     = (cnt_reg != '0) && (cnt_reg <= SLOT_W'(TOP_COUNT));
        rank_full = in_rd ? (cnt_reg - 1'b1) : (cnt_reg - SLOT_W'(TOP_COUNT + 1));
        rank_sel  = rank_full[RANK_W-1:0];
        sel_entry = in_rd ? rd_entries[rank_sel] : wr_entries[rank_sel];
        last_next = (cnt_reg == SLOT_W'(2 * TOP_COUNT));
        priority if (cnt_reg == '0)
        begin
            kind_next  = KIND_TOTAL;
            rank_next  = '0;
            uid_next   = '0;
            fr_next    = tot_fg_read_reg;
            br_next    = tot_bg_read_reg;
            fw_next    = tot_fg_write_reg;
            bw_next    = tot_bg_write_reg;
            fs_next    = tot_fg_sync_reg;
            bs_next    = tot_bg_sync_reg;
            shown_next = 1'b1;
        end
        else
        begin
            kind_next  = in_rd ? KIND_READ : KIND_WRITE;
            rank_next  = 4'(rank_full);
            uid_next   = sel_entry.uid;
            fr_next    = TOTAL_W'(sel_entry.fg_read);
            br_next    = TOTAL_W'(sel_entry.bg_read);
            fw_next    = TOTAL_W'(sel_entry.fg_write);
            bw_next    = TOTAL_W'(sel_entry.bg_write);
            fs_next    = TOTAL_W'(sel_entry.fg_sync);
            bs_next    = TOTAL_W'(sel_entry.bg_sync);
            shown_next = (in_rd ? rd_ok_reg : wr_ok_reg) && (sel_entry.key != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= beat_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat_valid)
        begin
            record_kind_reg  <= kind_next;
            rank_index_reg   <= rank_next;
            out_user_id_reg  <= uid_next;
            out_fg_read_reg  <= fr_next;
            out_bg_read_reg  <= br_next;
            out_fg_write_reg <= fw_next;
            out_bg_write_reg <= bw_next;
            out_fg_sync_reg  <= fs_next;
            out_bg_sync_reg  <= bs_next;
            shown_reg        <= shown_next;
            report_last_reg  <= last_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign record_kind  = record_kind_reg;
    assign rank_index   = rank_index_reg;
    assign out_user_id  = out_user_id_reg;
    assign out_fg_read  = out_fg_read_reg;
    assign out_bg_read  = out_bg_read_reg;
    assign out_fg_write = out_fg_write_reg;
    assign out_bg_write = out_bg_write_reg;
    assign out_fg_sync  = out_fg_sync_reg;
    assign out_bg_sync  = out_bg_sync_reg;
    assign shown        = shown_reg;
    assign report_last  = report_last_reg;

`ifndef ASSERT_OFF
    a_beat_from_report: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $past(state_reg == ST_REPORT))
        else $error("result beat without a report cycle");

    a_end_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && interval_end) |=> (state_reg == ST_DRAIN))
        else $error("interval end did not start the drain");

    a_last_ends_report: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && report_last_reg) |-> (!busy ##1 !out_valid_reg))
        else $error("report continued past its final beat");

    a_first_is_total: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg))
        |-> (record_kind_reg == KIND_TOTAL && shown_reg))
        else $error("report did not open with the totals beat");

    a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
        clear_lists |=> (tot_fg_read_reg == '0 && rd_entries[0].key == '0
                         && wr_entries[0].key == '0))
        else $error("lists or totals not cleared after the report");
`endif

endmodule

// ===== rtl/iotk_cell.sv =====
// ============================================================================
// iotk_cell: one compare-and-swap rank cell
// Keeps one rank entry. A carried entry with a strictly greater key takes
// the place and the old entry moves on, registered, to the next cell.
// ============================================================================
module iotk_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clear,
    input  iotk_pkg::entry_t carry_in,
    output iotk_pkg::entry_t carry_out,
    output iotk_pkg::entry_t entry
);
    import iotk_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    entry_t carry_reg;
    entry_t carry_next;
    logic   swap;

    always_comb
    begin
        swap = carry_in.key > entry_reg.key;
        if (clear)
        begin
            entry_next = '0;
            carry_next = '0;
        end
        else if (swap)
        begin
            entry_next = carry_in;
            carry_next = entry_reg;
        end
        else
        begin
            entry_next = entry_reg;
            carry_next = carry_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
            carry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
            carry_reg <= carry_next;
        end
    end

    assign carry_out = carry_reg;
    assign entry     = entry_reg;

endmodule

// ===== rtl/iotk_rank_chain.sv =====
// ============================================================================
// iotk_rank_chain: sorted top-K list as a row of rank cells
// A record enters rank 0 and travels one cell per cycle; the entry pushed
// past the last cell is dropped.
// ============================================================================
module iotk_rank_chain #(
    parameter int TOP_COUNT = iotk_pkg::TOP_COUNT_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clear,
    input  iotk_pkg::entry_t rec_in,
    output iotk_pkg::entry_t entries [TOP_COUNT]
);
    import iotk_pkg::*;

    entry_t link [TOP_COUNT+1];

    assign link[0] = rec_in;

    for (genvar g = 0; g < TOP_COUNT; g++)
    begin : g_cell
        iotk_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .clear     (clear),
            .carry_in  (link[g]),
            .carry_out (link[g+1]),
            .entry     (entries[g])
        );
    end

endmodule
